[design/usrng_pkg.sv]
// shared types, register indexes and distance helpers for the ultrasonic ranger
package usrng_pkg;

   typedef enum logic [1:0] {
      PH_TRIG,
      PH_RISE,
      PH_ECHO,
      PH_WAIT
   } phase_type;

   localparam logic [2:0] CSR_TRIGGER_TICKS = 3'd0;
   localparam logic [2:0] CSR_ECHO_TIMEOUT  = 3'd1;
   localparam logic [2:0] CSR_WIDTH_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_TICKS_PER_MS  = 3'd3;
   localparam logic [2:0] CSR_IDLE_WAIT_MS  = 3'd4;

   localparam logic [7:0]  ERR_DIST    = 8'hFF;
   localparam logic [7:0]  NEAR_LIMIT  = 8'd30;
   localparam logic [7:0]  DIST_MAX    = 8'd254;
   // count*34/2000 reaches 255 exactly from this count up
   localparam logic [15:0] SAT_COUNT   = 16'd15000;
   // 17 * ceil(2^30 / 1000): count*17/1000 as multiply and shift
   localparam logic [24:0] DIST_RECIP  = 25'd18253614;
   localparam int          DIST_SHIFT  = 30;

   typedef struct packed {
      logic [9:0]  trigger_ticks;
      logic [15:0] echo_start_timeout;
      logic [15:0] echo_width_limit;
      logic [15:0] ticks_per_ms;
      logic [9:0]  idle_wait_ms;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic echo;
   } qhead_type;

   // blink half period in ms for a near distance (0..30 cm)
   function automatic logic [5:0] half_period_ms(input logic [7:0] dist_cm);
      logic [5:0] hp;
      if (dist_cm <= 8'd3)       hp = 6'd5;
      else if (dist_cm <= 8'd6)  hp = 6'd6;
      else if (dist_cm <= 8'd10) hp = 6'd7;
      else if (dist_cm <= 8'd13) hp = 6'd8;
      else if (dist_cm <= 8'd16) hp = 6'd10;
      else if (dist_cm <= 8'd20) hp = 6'd12;
      else if (dist_cm <= 8'd23) hp = 6'd16;
      else if (dist_cm <= 8'd26) hp = 6'd25;
      else                       hp = 6'd50;
      return hp;
   endfunction

endpackage

[design/usrng_front.sv]
// input side: accepts echo ticks into a two-entry queue
module usrng_front import usrng_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] echo_level
   input  logic       pop,
   output qhead_type  head
);

   logic [1:0] echo_q_ff;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.echo  = echo_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         echo_q_ff[wr_ptr_ff] <= req_tdata[0];
      end
   end

endmodule

[design/usrng_core.sv]
// back side: trigger, echo timing, distance and blink wait sequencer
module usrng_core import usrng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  qhead_type   head,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [0] trigger_level, [1] led_level, [9:2] distance_cm,
                                   // [10] object_near
   output logic        rsp_tlast   // measure_done
);

   phase_type   phase_ff, phase_in;
   logic [15:0] pulse_ff, pulse_in;
   logic [15:0] wait_ff, wait_in;
   logic        led_ff, led_in;
   logic [7:0]  dist_ff, dist_in;
   logic        near_ff, near_in;

   logic        rsp_valid_ff;
   logic [10:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic        trig;
   logic        done;
   logic        finish;
   logic [7:0]  fin_dist;
   logic [16:0] pulse_inc;
   logic [16:0] wait_inc;
   logic [38:0] dist_prod;
   logic [7:0]  echo_dist;
   logic [9:0]  wait_len;

   assign pop       = head.valid && (!rsp_valid_ff || rsp_tready);
   assign pulse_inc = {1'b0, pulse_ff} + 17'd1;
   assign wait_inc  = {1'b0, wait_ff} + 17'd1;

   assign dist_prod = pulse_ff[13:0] * DIST_RECIP;
   assign echo_dist = (pulse_ff >= SAT_COUNT) ? DIST_MAX
                                              : dist_prod[DIST_SHIFT+7:DIST_SHIFT];
   assign wait_len  = near_ff ? {4'd0, half_period_ms(dist_ff)} : cfg.idle_wait_ms;

   always_comb begin
      phase_in = phase_ff;
      pulse_in = pulse_ff;
      wait_in  = wait_ff;
      trig     = 1'b0;
      done     = 1'b0;
      finish   = 1'b0;
      fin_dist = ERR_DIST;
      unique case (phase_ff)
         PH_TRIG: begin
            trig = 1'b1;
            if (pulse_inc >= {7'd0, cfg.trigger_ticks}) begin
               phase_in = PH_RISE;
               pulse_in = 16'd0;
            end else begin
               pulse_in = pulse_inc[15:0];
            end
         end
         PH_RISE: begin
            if (head.echo) begin
               phase_in = PH_ECHO;
               pulse_in = 16'd0;
            end else if (pulse_ff >= cfg.echo_start_timeout) begin
               finish = 1'b1;
            end else begin
               pulse_in = pulse_inc[15:0];
            end
         end
         PH_ECHO: begin
            if (head.echo) begin
               if (pulse_ff >= cfg.echo_width_limit) begin
                  finish = 1'b1;
               end else begin
                  pulse_in = pulse_inc[15:0];
               end
            end else begin
               finish   = 1'b1;
               fin_dist = echo_dist;
            end
         end
         PH_WAIT: begin
            if (wait_inc >= {1'b0, cfg.ticks_per_ms}) begin
               wait_in = 16'd0;
               if (pulse_inc >= {7'd0, wait_len}) begin
                  phase_in = PH_TRIG;
                  pulse_in = 16'd0;
               end else begin
                  pulse_in = pulse_inc[15:0];
               end
            end else begin
               wait_in = wait_inc[15:0];
            end
         end
         default: begin
            phase_in = PH_TRIG;
            pulse_in = 16'd0;
            wait_in  = 16'd0;
         end
      endcase

      dist_in = dist_ff;
      near_in = near_ff;
      led_in  = led_ff;
      if (finish) begin
         done     = 1'b1;
         phase_in = PH_WAIT;
         pulse_in = 16'd0;
         wait_in  = 16'd0;
         dist_in  = fin_dist;
         near_in  = (fin_dist <= NEAR_LIMIT);
         led_in   = near_in ? ~led_ff : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIG;
         pulse_ff <= 16'd0;
         wait_ff  <= 16'd0;
         led_ff   <= 1'b0;
         dist_ff  <= 8'd0;
         near_ff  <= 1'b0;
      end else if (pop) begin
         phase_ff <= phase_in;
         pulse_ff <= pulse_in;
         wait_ff  <= wait_in;
         led_ff   <= led_in;
         dist_ff  <= dist_in;
         near_ff  <= near_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= {near_in, dist_in, led_in, trig};
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[design/ultrasonic_ranger_with_proximity_blink.sv]
// ultrasonic ranger top level: register file, input queue and sequencer
// an accepted tick waits in the queue; its result is then held in the result register
// throughput: one tick per cycle while the result output is not stalled
// a two-entry queue parts input from sequencer; the result register parts it from output
// reset: synchronous, clears queue, sequencer (trigger phase, counters zero, led off,
// distance zero) and restores register defaults
module ultrasonic_ranger_with_proximity_blink import usrng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] echo_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] trigger_level, [1] led_level, [9:2] distance_cm,
                                    // [10] object_near
   output logic        rsp_tlast,   // measure_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type   cfg_ff;
   qhead_type head;
   logic      pop;
   logic      csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks      <= 10'd10;
         cfg_ff.echo_start_timeout <= 16'd30000;
         cfg_ff.echo_width_limit   <= 16'd30000;
         cfg_ff.ticks_per_ms       <= 16'd1000;
         cfg_ff.idle_wait_ms       <= 10'd100;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TRIGGER_TICKS: cfg_ff.trigger_ticks      <= csr_data[9:0];
            CSR_ECHO_TIMEOUT:  cfg_ff.echo_start_timeout <= csr_data;
            CSR_WIDTH_LIMIT:   cfg_ff.echo_width_limit   <= csr_data;
            CSR_TICKS_PER_MS:  cfg_ff.ticks_per_ms       <= csr_data;
            CSR_IDLE_WAIT_MS:  cfg_ff.idle_wait_ms       <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   usrng_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head)
   );

   usrng_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/usrng_checker.sv]
// port-level checks for the ultrasonic ranger, bound to the top level
module usrng_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // an error distance is never near
   a_err_far: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:2] == 8'hFF |-> !rsp_tdata[10])
      else $error("error distance flagged near");

   a_near_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:2] <= 8'd30)
      else $error("near flag with distance above limit");

   // led only blinks while an object is near
   a_led_near: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[10] |-> !rsp_tdata[1])
      else $error("led on with no object near");

   a_trig_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tlast)
      else $error("measurement finished during trigger");

endmodule

bind ultrasonic_ranger_with_proximity_blink usrng_checker u_usrng_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/sv/ranger_tick_compare.sv]
`timescale 1ns / 100ps
// tick-by-tick predictor and result comparison for the ultrasonic ranger testbench
module ranger_tick_compare import usrng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          outstanding
);

   typedef struct packed {
      logic       trigger;
      logic       led;
      logic       done;
      logic [7:0] distance;
      logic       near;
   } tick_out_type;

   tick_out_type expected_ticks[$];

   cfg_type     regs;
   phase_type   ph;
   int unsigned pulse_cnt;
   int unsigned ms_tick_cnt;
   logic        led_on;
   logic        near_on;
   logic [7:0]  dist_held;
   int          rsp_count = 0;

   task automatic flag_mismatch(input string msg);
      if (fail_count < 50)
         $display("%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got)
         flag_mismatch($sformatf("result %0d: %s expected %0d got %0d",
                                 rsp_count, name, want, got));
   endtask

   function automatic void reset_model();
      regs.trigger_ticks      = 10'd10;
      regs.echo_start_timeout = 16'd30000;
      regs.echo_width_limit   = 16'd30000;
      regs.ticks_per_ms       = 16'd1000;
      regs.idle_wait_ms       = 10'd100;
      ph          = PH_TRIG;
      pulse_cnt   = 0;
      ms_tick_cnt = 0;
      led_on      = 1'b0;
      near_on     = 1'b0;
      dist_held   = '0;
   endfunction

   // blink half period: freq runs 1..10 over 30 cm down to 0 cm, half period is 50/freq ms
   function automatic int unsigned blink_half_ms(input logic [7:0] d);
      int unsigned freq;
      freq = (d == 0) ? 10 : 1 + ((30 - int'(d)) * 9) / 30;
      case (freq)
         0, 1:    return 50;
         2:       return 25;
         3:       return 16;
         4:       return 12;
         5:       return 10;
         6:       return 8;
         7:       return 7;
         8:       return 6;
         default: return 5;
      endcase
   endfunction

   function automatic int unsigned hold_ms();
      return near_on ? blink_half_ms(dist_held) : int'(regs.idle_wait_ms);
   endfunction

   function automatic void close_measurement(input logic [7:0] d);
      dist_held   = d;
      near_on     = (d <= NEAR_LIMIT);
      led_on      = near_on ? ~led_on : 1'b0;
      ph          = PH_WAIT;
      pulse_cnt   = 0;
      ms_tick_cnt = 0;
   endfunction

   function automatic tick_out_type advance(input logic echo);
      tick_out_type o;
      int unsigned  d;
      o = '0;
      case (ph)
         PH_TRIG: begin
            o.trigger = 1'b1;
            if (pulse_cnt + 1 >= regs.trigger_ticks) begin
               ph        = PH_RISE;
               pulse_cnt = 0;
            end else begin
               pulse_cnt = (pulse_cnt + 1) & 16'hFFFF;
            end
         end
         PH_RISE: begin
            if (echo) begin
               ph        = PH_ECHO;
               pulse_cnt = 0;
            end else if (pulse_cnt >= regs.echo_start_timeout) begin
               close_measurement(ERR_DIST);
               o.done = 1'b1;
            end else begin
               pulse_cnt = (pulse_cnt + 1) & 16'hFFFF;
            end
         end
         PH_ECHO: begin
            if (echo) begin
               if (pulse_cnt >= regs.echo_width_limit) begin
                  close_measurement(ERR_DIST);
                  o.done = 1'b1;
               end else begin
                  pulse_cnt = (pulse_cnt + 1) & 16'hFFFF;
               end
            end else begin
               d = (pulse_cnt * 34) / 2000;
               if (d > DIST_MAX)
                  d = DIST_MAX;
               close_measurement(d[7:0]);
               o.done = 1'b1;
            end
         end
         default: begin
            // wait counts ticks within a ms, then whole ms against the current hold time
            if (ms_tick_cnt + 1 >= regs.ticks_per_ms) begin
               ms_tick_cnt = 0;
               if (pulse_cnt + 1 >= hold_ms()) begin
                  ph        = PH_TRIG;
                  pulse_cnt = 0;
               end else begin
                  pulse_cnt = (pulse_cnt + 1) & 16'hFFFF;
               end
            end else begin
               ms_tick_cnt = (ms_tick_cnt + 1) & 20'hFFFFF;
            end
         end
      endcase
      o.led      = led_on;
      o.distance = dist_held;
      o.near     = near_on;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      tick_out_type got;
      tick_out_type want;
      if (reset) begin
         reset_model();
         expected_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRIGGER_TICKS: regs.trigger_ticks      = csr_data[9:0];
               CSR_ECHO_TIMEOUT:  regs.echo_start_timeout = csr_data;
               CSR_WIDTH_LIMIT:   regs.echo_width_limit   = csr_data;
               CSR_TICKS_PER_MS:  regs.ticks_per_ms       = csr_data;
               CSR_IDLE_WAIT_MS:  regs.idle_wait_ms       = csr_data[9:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_ticks.push_back(advance(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            got.trigger  = rsp_tdata[0];
            got.led      = rsp_tdata[1];
            got.distance = rsp_tdata[9:2];
            got.near     = rsp_tdata[10];
            got.done     = rsp_tlast;
            if (expected_ticks.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with no tick pending", rsp_count));
            end else begin
               want = expected_ticks.pop_front();
               check_field("trigger_level", want.trigger, got.trigger);
               check_field("led_level", want.led, got.led);
               check_field("measure_done", want.done, got.done);
               check_field("distance_cm", want.distance, got.distance);
               check_field("object_near", want.near, got.near);
            end
            rsp_count++;
         end
      end
      outstanding = expected_ticks.size();
   end

endmodule

[tb/sv/tb_ultrasonic_ranger_with_proximity_blink.sv]
`timescale 1ns / 100ps
// top-level testbench for the ultrasonic ranger: clock, reset, stimulus and verdict
module tb_ultrasonic_ranger_with_proximity_blink;
   import usrng_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   // trigger, rise timeout at once, width overflow, short echo and a blink wait
   localparam logic [0:20] DIRECTED_ECHO = 21'b000111111001000000010;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;     // [0] echo_level
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;     // [0] trigger_level, [1] led_level, [9:2] distance_cm,
                               // [10] object_near
   logic        rsp_tlast;     // measure_done
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int fail_count;
   int outstanding;
   bit req_idle;
   bit rsp_idle;
   int rsp_hold = 0;
   int rsp_gap;
   int quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ultrasonic_ranger_with_proximity_blink DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ranger_tick_compare u_compare (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_gap = pick_gap(rsp_idle);
         rsp_tready <= (rsp_gap == 0);
         rsp_hold   <= (rsp_gap > 0) ? rsp_gap - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_ultrasonic_ranger_with_proximity_blink: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_tick(input logic echo);
      int gap;
      gap = pick_gap(req_idle);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, echo};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] trig, input logic [15:0] rise_to,
                               input logic [15:0] width_lim, input logic [15:0] tpm,
                               input logic [15:0] idle_ms);
      write_reg(CSR_TRIGGER_TICKS, trig);
      write_reg(CSR_ECHO_TIMEOUT, rise_to);
      write_reg(CSR_WIDTH_LIMIT, width_lim);
      write_reg(CSR_TICKS_PER_MS, tpm);
      write_reg(CSR_IDLE_WAIT_MS, idle_ms);
      csr_valid <= 1'b0;
   endtask

   // every tick gives one result, so once none is outstanding the block is idle
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic echo_burst(input int quiet, input int width);
      repeat (quiet) send_tick(1'b0);
      repeat (width) send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // mostly well-formed echo pulses, some broken runs of random levels;
   // the last run is cut short so that exactly budget ticks go out
   task automatic run_bursts(input int budget, input int max_quiet, input int max_width);
      int sent;
      int r;
      int q;
      int w;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            q = $urandom_range(1, 30);
            if (q > budget - sent)
               q = budget - sent;
            repeat (q) send_tick(1'($urandom_range(0, 1)));
            sent += q;
         end else begin
            q = ($urandom_range(0, 99) < 60) ? $urandom_range(0, max_quiet / 4)
                                             : $urandom_range(0, max_quiet);
            r = $urandom_range(0, 99);
            if (r < 65)
               w = $urandom_range(0, max_width / 10);
            else if (r < 88)
               w = $urandom_range(0, max_width);
            else
               w = $urandom_range(max_width, max_width + max_width / 3);
            if (q + 1 > budget - sent)
               q = budget - sent - 1;
            if (q + w + 1 > budget - sent)
               w = budget - sent - q - 1;
            echo_burst(q, w);
            sent += q + w + 1;
         end
      end
   endtask

   initial begin : stimulus
      logic [15:0] trig_v;
      logic [15:0] rise_v;
      logic [15:0] width_v;
      logic [15:0] tpm_v;
      logic [15:0] idle_v;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_TRIGGER_TICKS;
      csr_data   = '0;
      req_idle   = 1'b0;
      rsp_idle   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset registers: still in the trigger pulse, echo is ignored
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);

      // zero registers, width limit of three
      drain_outputs();
      program_regs(16'h0000, 16'h0000, 16'd3, 16'h0000, 16'h0000);
      for (int i = 0; i < 21; i++)
         send_tick(DIRECTED_ECHO[i]);

      // timeouts and waits at the top, trigger written with bits beyond its width
      drain_outputs();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      program_regs(16'hFC02, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      echo_burst(40, 200);
      repeat (10) send_tick(1'b0);

      // all registers at one, back-to-back with no idling
      drain_outputs();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      run_bursts(150, 4, 4);

      for (int p = 0; p < 3; p++) begin
         drain_outputs();
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         trig_v  = ($urandom_range(0, 99) < 15) ? 16'($urandom())
                                                : 16'($urandom_range(1, 12));
         rise_v  = ($urandom_range(0, 99) < 40) ? 16'($urandom_range(1, 60))
                                                : 16'($urandom_range(200, 65535));
         width_v = ($urandom_range(0, 99) < 30) ? 16'($urandom_range(1, 400))
                                                : 16'($urandom_range(1900, 65535));
         tpm_v   = ($urandom_range(0, 99) < 10) ? 16'h0000
                                                : 16'($urandom_range(1, 3));
         idle_v  = ($urandom_range(0, 99) < 15) ? 16'($urandom())
                                                : 16'($urandom_range(1, 6));
         program_regs(trig_v, rise_v, width_v, tpm_v, idle_v);
         run_bursts(500, 200, 1850);
      end

      drain_outputs();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("tb_ultrasonic_ranger_with_proximity_blink: PASS");
      else
         $display("tb_ultrasonic_ranger_with_proximity_blink: FAIL");
      $finish;
   end

endmodule

[filelist.f]
design/usrng_pkg.sv
design/usrng_front.sv
design/usrng_core.sv
design/ultrasonic_ranger_with_proximity_blink.sv
design/usrng_checker.sv
tb/sv/ranger_tick_compare.sv
tb/sv/tb_ultrasonic_ranger_with_proximity_blink.sv
